// ===== rtl/sbe_pkg.sv =====
`default_nettype none
package sbe_pkg;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [16:0]        frame_index;
    logic [11:0]        bin_index;
  } in_t;

  typedef struct packed {
    logic signed [23:0] real_part;
    logic signed [23:0] imag_part;
    logic               status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_CHECK, S_MOD, S_RUN, S_DRAIN, S_ROUND, S_SCALE, S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_BIN   = 1'b1;

  localparam logic REG_SIGNAL_LENGTH = 1'b0;
  localparam logic REG_HOP_SIZE      = 1'b1;

  localparam logic [16:0] LENGTH_RESET = 17'd1;
  localparam logic [12:0] HOP_RESET    = 13'd1024;

  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  // round to nearest, halves away from zero
  function automatic longint round_shift(input longint v, input int sh);
    longint h;
    longint r;
    h = longint'(1) <<< (sh - 1);
    if (v >= 0) begin
      r = (v + h) >>> sh;
    end else begin
      r = -((-v + h) >>> sh);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/stft_bin_engine.sv =====
`default_nettype none
// channel   ports                              transaction
// input     start, busy, in_data               start && !busy
// result    out_strobe, out_data               out_strobe, one cycle
// config    cfg_we, cfg_index, cfg_wdata       cfg_we
//
// sample write: busy stays low
// bin request: busy through set-up, the start-position modulo (skipped at length one),
// the run through the single multiply-accumulate path (one signal memory read a cycle),
// then drain, rounding and scaling; out-of-range frames leave busy after the set-up
// the result strobe comes in the same cycle that busy falls
// synchronous active-low reset; the receiver cannot stall results
module stft_bin_engine #(
  parameter int FFT_SIZE     = 4096,
  parameter int SIGNAL_DEPTH = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sbe_pkg::in_t  in_data,
  output logic               out_strobe,
  output sbe_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [16:0]   cfg_wdata
);
  import sbe_pkg::*;

  localparam int LN    = $clog2(FFT_SIZE);
  localparam int AW    = $clog2(SIGNAL_DEPTH);
  localparam int ACC_W = 49 + LN;

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned vv;
    longint unsigned res;
    longint unsigned b;
    vv  = v;
    res = 0;
    b   = 64'd1 << 62;
    while (b > vv) b = b >> 2;
    while (b != 0) begin
      if (vv >= res + b) begin
        vv  = vv - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  localparam logic [31:0] INV_Q31 = 32'(isqrt((64'd1 << 62) / FFT_SIZE));

  state_t state_r, state_nxt;
  mac_ctl_t mac_ctl;

  logic [16:0]        len_cfg_r;
  logic [12:0]        hop_cfg_r;
  logic [AW:0]        len_eff;
  logic [12:0]        hop_eff;
  logic [AW:0]        period;
  logic [16:0]        frame_r;
  logic [LN-1:0]      step_r;
  logic [29:0]        prod_r;
  logic signed [31:0] st;
  logic               neg_r;
  logic [29:0]        mag_r;
  logic [AW:0]        rem_r;
  logic [AW+1:0]      rem_sh;
  logic [4:0]         cnt_r;
  logic [AW:0]        u_r;
  logic [LN-1:0]      i_r, m_r;
  logic [1:0]         drain_r;
  logic [AW-1:0]      raddr;
  logic               len_one;
  logic               mem_we;
  logic signed [15:0] sample;
  logic signed [31:0] win_cos, cos_v, sin_v;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [31:0] rr_r, ri_r;
  logic signed [63:0] pr_r, pi_r;
  longint             vre, vim;

  assign len_eff = (len_cfg_r == 17'd0) ? (AW+1)'(1) :
                   (32'(len_cfg_r) > 32'(SIGNAL_DEPTH)) ? (AW+1)'(SIGNAL_DEPTH) :
                   (AW+1)'(len_cfg_r);
  assign hop_eff = (hop_cfg_r == 13'd0) ? 13'd1 : hop_cfg_r;
  assign period  = (AW+1)'(2 * (32'(len_eff) - 32'd1));
  assign len_one = len_eff == (AW+1)'(1);
  assign st      = $signed({2'b0, prod_r}) - 32'(FFT_SIZE / 2);
  assign rem_sh  = {rem_r, mag_r[29]};
  assign raddr   = len_one ? '0 : (u_r < len_eff) ? u_r[AW-1:0] : AW'(period - u_r);
  assign mem_we  = state_r == S_IDLE && start && in_data.req_type == REQ_WRITE &&
                   32'(in_data.sample_index) < 32'(SIGNAL_DEPTH);

  sbe_sig_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(AW'(in_data.sample_index)),
    .wdata(in_data.sample_value), .raddr(raddr), .rdata(sample)
  );

  sbe_cos_rom #(.FFT_SIZE(FFT_SIZE), .LN(LN)) u_win_rom (
    .clk(clk), .addr(i_r), .data(win_cos)
  );

  sbe_cos_rom #(.FFT_SIZE(FFT_SIZE), .LN(LN)) u_cos_rom (
    .clk(clk), .addr(m_r), .data(cos_v)
  );

  sbe_cos_rom #(.FFT_SIZE(FFT_SIZE), .LN(LN)) u_sin_rom (
    .clk(clk), .addr(m_r - LN'(FFT_SIZE / 4)), .data(sin_v)
  );

  sbe_mac #(.ACC_W(ACC_W)) u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .sample(sample), .win_cos(win_cos),
    .cos_val(cos_v), .sin_val(sin_v), .acc_re(acc_re), .acc_im(acc_im)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start && in_data.req_type == REQ_BIN) state_nxt = S_PROD;
      S_PROD:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (32'(prod_r) > 32'(len_eff)) state_nxt = S_IDLE;
        else if (len_one) state_nxt = S_RUN;
        else state_nxt = S_MOD;
      end
      S_MOD:   if (cnt_r == 5'd29) state_nxt = S_RUN;
      S_RUN:   if (i_r == LN'(FFT_SIZE - 1)) state_nxt = S_DRAIN;
      S_DRAIN: if (drain_r == 2'd2) state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = state_r != S_IDLE;
    mac_ctl.issue = state_r == S_RUN;
    mac_ctl.clear = state_r == S_CHECK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_cfg_r  <= LENGTH_RESET;
      hop_cfg_r  <= HOP_RESET;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == S_CHECK && 32'(prod_r) > 32'(len_eff)) ||
                    state_r == S_DONE;
      if (cfg_we) begin
        case (cfg_index)
          REG_SIGNAL_LENGTH: len_cfg_r <= cfg_wdata;
          REG_HOP_SIZE:      hop_cfg_r <= cfg_wdata[12:0];
          default:           ;
        endcase
      end
    end
  end

  assign vre = round_shift(longint'(pr_r), 31);
  assign vim = round_shift(longint'(pi_r), 31);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        frame_r <= in_data.frame_index;
        step_r  <= LN'(in_data.bin_index);
      end
      S_PROD: prod_r <= 30'(frame_r * hop_eff);
      S_CHECK: begin
        neg_r    <= st[31];
        mag_r    <= st[31] ? 30'(-st) : 30'(st);
        rem_r    <= '0;
        cnt_r    <= '0;
        u_r      <= '0;
        i_r      <= '0;
        m_r      <= '0;
        out_data <= '{real_part: '0, imag_part: '0, status: 1'b1};
      end
      S_MOD: begin
        cnt_r <= cnt_r + 5'd1;
        mag_r <= {mag_r[28:0], 1'b0};
        if (cnt_r == 5'd29) begin
          if (rem_sh >= {1'b0, period}) begin
            u_r <= (neg_r && (rem_sh - {1'b0, period}) != '0) ?
                   period - (AW+1)'(rem_sh - {1'b0, period}) :
                   (AW+1)'(rem_sh - {1'b0, period});
          end else begin
            u_r <= (neg_r && rem_sh != '0) ? period - (AW+1)'(rem_sh) : (AW+1)'(rem_sh);
          end
        end else if (rem_sh >= {1'b0, period}) begin
          rem_r <= (AW+1)'(rem_sh - {1'b0, period});
        end else begin
          rem_r <= (AW+1)'(rem_sh);
        end
      end
      S_RUN: begin
        i_r     <= i_r + LN'(1);
        m_r     <= m_r + step_r;
        u_r     <= (u_r + (AW+1)'(1) >= period) ? '0 : u_r + (AW+1)'(1);
        drain_r <= '0;
      end
      S_DRAIN: drain_r <= drain_r + 2'd1;
      S_ROUND: begin
        rr_r <= 32'(round_shift(longint'(acc_re), 30));
        ri_r <= 32'(round_shift(longint'(acc_im), 30));
      end
      S_SCALE: begin
        pr_r <= rr_r * $signed(INV_Q31);
        pi_r <= ri_r * $signed(INV_Q31);
      end
      S_DONE: begin
        out_data.status    <= 1'b0;
        out_data.real_part <= (vre > OUT_MAX) ? 24'sh7fffff :
                              (vre < OUT_MIN) ? 24'sh800000 : 24'(vre);
        out_data.imag_part <= (vim > OUT_MAX) ? 24'sh7fffff :
                              (vim < OUT_MIN) ? 24'sh800000 : 24'(vim);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sbe_sig_mem.sv =====
`default_nettype none
module sbe_sig_mem #(
  parameter int AW = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic signed [15:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic signed [15:0]     rdata
);

  logic signed [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/sbe_cos_rom.sv =====
`default_nettype none
module sbe_cos_rom #(
  parameter int FFT_SIZE = 4096,
  parameter int LN       = 12
) (
  input  wire logic          clk,
  input  wire logic [LN-1:0] addr,
  output logic signed [31:0] data
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned DS [7] = '{1, 6, 20, 42, 72, 110, 156};
  localparam longint unsigned DC [7] = '{1, 2, 12, 30, 56, 90, 132};

  // cos(2*pi*m/FFT_SIZE) in q2.30 via eighth-turn taylor series
  function automatic logic signed [31:0] cos_val(input int m);
    longint unsigned f;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cc;
    longint t;
    longint res;
    logic sw;
    f  = 4 * longint'(m);
    q  = f / FFT_SIZE;
    r  = f - q * FFT_SIZE;
    sw = (2 * r) > FFT_SIZE;
    if (sw) r = FFT_SIZE - r;
    x  = (HALF_PI_Q30 * r + FFT_SIZE / 2) / FFT_SIZE;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = longint'(x);
    cc = ONE_Q30;
    for (int k = 1; k <= 6; k++) begin
      ts = ((ts * x2) >> 30) / DS[k];
      tc = ((tc * x2) >> 30) / DC[k];
      if (k % 2 == 1) begin
        ss = ss - longint'(ts);
        cc = cc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cc = cc + longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (ss > ONE_Q30) ss = ONE_Q30;
    if (cc < 0) cc = 0;
    if (cc > ONE_Q30) cc = ONE_Q30;
    if (sw) begin
      t  = ss;
      ss = cc;
      cc = t;
    end
    case (q % 4)
      0:       res = cc;
      1:       res = -ss;
      2:       res = -cc;
      default: res = ss;
    endcase
    return res[31:0];
  endfunction

  logic signed [31:0] rom [FFT_SIZE];

  for (genvar g = 0; g < FFT_SIZE; g++) begin : g_rom
    localparam logic signed [31:0] VAL = cos_val(g);
    assign rom[g] = VAL;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/sbe_mac.sv =====
`default_nettype none
module sbe_mac #(
  parameter int ACC_W = 61
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sbe_pkg::mac_ctl_t  ctl,
  input  wire logic signed [15:0] sample,
  input  wire logic signed [31:0] win_cos,
  input  wire logic signed [31:0] cos_val,
  input  wire logic signed [31:0] sin_val,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im
);
  import sbe_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic [30:0]        win;
  logic signed [46:0] wprod_r;
  logic signed [31:0] cos_d_r, sin_d_r;
  logic signed [16:0] xw;
  logic signed [48:0] term_re_r, term_im_r;

  // periodic hann from the cosine at the sample's index within the frame
  assign win = 31'((33'sd1073741824 - 33'(win_cos)) >>> 1);
  assign xw  = 17'(round_shift(longint'(wprod_r), 30));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    wprod_r   <= 47'(sample * $signed({1'b0, win}));
    cos_d_r   <= cos_val;
    sin_d_r   <= sin_val;
    term_re_r <= 49'(xw * cos_d_r);
    term_im_r <= 49'(xw * sin_d_r);
    if (ctl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v3_r) begin
      acc_re <= acc_re + ACC_W'(term_re_r);
      acc_im <= acc_im - ACC_W'(term_im_r);
    end
  end

endmodule
`default_nettype wire

// ===== verif/stft_bin_engine_tb.sv =====
`timescale 1ns / 1ps
module stft_bin_engine_tb;
  import sbe_pkg::*;

  localparam int N = 4096;
  localparam int DEPTH = 65536;
  localparam longint INV_SQRT_Q31 = 64'sd33554432;  // 1/sqrt(4096) in Q31
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IN_W = $bits(in_t);

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_strobe;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = '0;

  stft_bin_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  int                 cos_q30 [N];
  int                 sin_q30 [N];
  int                 hann_q30 [N];
  logic signed [15:0] samples [DEPTH];
  logic [16:0]        length_reg;
  logic [12:0]        hop_reg;
  out_t               pending_bins [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  int                 filled = 0;
  bit                 gaps_on = 1'b1;

  function automatic longint round_q(input longint v, input int sh);
    longint h;
    h = longint'(1) << (sh - 1);
    if (v >= 0) return (v + h) >>> sh;
    return -((-v + h) >>> sh);
  endfunction

  // sin/cos of (pi/2)*r/N in Q30 by truncated series
  task automatic eighth_turn(input longint unsigned r, output longint s, output longint c);
    longint unsigned x, x2, ts, tc;
    longint ss, cc;
    x = (64'd1686629713 * r + N / 2) / N;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1073741824;
    ss = x;
    cc = 64'sd1073741824;
    for (int k = 1; k <= 6; k++) begin
      ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= ts;
        cc -= tc;
      end else begin
        ss += ts;
        cc += tc;
      end
    end
    s = ss < 0 ? 0 : (ss > 64'sd1073741824 ? 64'sd1073741824 : ss);
    c = cc < 0 ? 0 : (cc > 64'sd1073741824 ? 64'sd1073741824 : cc);
  endtask

  task automatic build_trig();
    longint unsigned f, q, r;
    longint s, c, t;
    bit sw;
    for (int m = 0; m < N; m++) begin
      f = 4 * m;
      q = f / N;
      r = f - q * N;
      sw = (2 * r > N);
      if (sw) r = N - r;
      eighth_turn(r, s, c);
      if (sw) begin
        t = s;
        s = c;
        c = t;
      end
      case (q % 4)
        0: begin cos_q30[m] = c;  sin_q30[m] = s;  end
        1: begin cos_q30[m] = -s; sin_q30[m] = c;  end
        2: begin cos_q30[m] = -c; sin_q30[m] = -s; end
        default: begin cos_q30[m] = s; sin_q30[m] = -c; end
      endcase
      hann_q30[m] = (64'sd1073741824 - longint'(cos_q30[m])) >>> 1;
    end
  endtask

  function automatic logic signed [23:0] scale_sat(input longint acc);
    longint v;
    v = round_q(round_q(acc, 30) * INV_SQRT_Q31, 31);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  function automatic longint eff_len();
    if (length_reg == 0) return 1;
    if (length_reg > DEPTH) return DEPTH;
    return length_reg;
  endfunction

  function automatic longint frame_count();
    return eff_len() / (hop_reg == 0 ? 1 : hop_reg) + 1;
  endfunction

  function automatic out_t compute_bin(input in_t it);
    out_t o;
    longint len, hop, pos, a, period, first, re, im, xw;
    int m, stepm;
    len = eff_len();
    hop = hop_reg == 0 ? 1 : hop_reg;
    o = '0;
    if (longint'(it.frame_index) >= frame_count()) begin
      o.status = 1'b1;
      return o;
    end
    first = longint'(it.frame_index) * hop - N / 2;
    period = 2 * (len - 1);
    stepm = it.bin_index % N;
    m = 0;
    re = 0;
    im = 0;
    for (int i = 0; i < N; i++) begin
      pos = first + i;
      a = 0;
      if (len > 1) begin
        a = (pos < 0 ? -pos : pos) % period;
        if (a >= len) a = period - a;
      end
      xw = round_q(longint'(samples[a]) * longint'(hann_q30[i]), 30);
      re += xw * longint'(cos_q30[m]);
      im -= xw * longint'(sin_q30[m]);
      m += stepm;
      if (m >= N) m -= N;
    end
    o.real_part = scale_sat(re);
    o.imag_part = scale_sat(im);
    return o;
  endfunction

  function automatic in_t write_req(input int idx, input int val);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom}));
    it.req_type = REQ_WRITE;
    it.sample_index = idx[15:0];
    it.sample_value = val[15:0];
    return it;
  endfunction

  function automatic in_t bin_req(input int frame, input int bin);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom}));
    it.req_type = REQ_BIN;
    it.frame_index = frame[16:0];
    it.bin_index = bin[11:0];
    return it;
  endfunction

  task automatic send(input in_t it, input bit fixed, input out_t want);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (it.req_type == REQ_WRITE) begin
      samples[it.sample_index] = it.sample_value;
    end else begin
      pending_bins.push_back(fixed ? want : compute_bin(it));
    end
    if (gaps_on && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_bins.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_SIGNAL_LENGTH) length_reg = val[16:0];
    else hop_reg = val[12:0];
  endtask

  // writes every sample below the length that is not yet written
  task automatic fill_signal();
    int v;
    for (int i = filled; i < eff_len(); i++) begin
      v = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 32767 : -32768) : $urandom;
      send(write_req(i, v), 1'b0, '0);
    end
    if (eff_len() > filled) filled = int'(eff_len());
  endtask

  task automatic random_traffic(input int count, input bit beyond_only = 1'b0);
    int fc;
    for (int n = 0; n < count; n++) begin
      fc = frame_count();
      if ($urandom_range(0, 9) < 3) begin
        send(write_req($urandom, $urandom), 1'b0, '0);
      end else begin
        send(bin_req((beyond_only || $urandom_range(0, 9) == 0) ? $urandom_range(fc, 131071)
                                                               : $urandom_range(0, fc - 1),
                     $urandom_range(0, 9) == 0 ? $urandom_range(2049, 4095)
                                               : $urandom_range(0, 2048)),
             1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_strobe)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_t want;
        want = pending_bins.pop_front();
        if (out_data.real_part !== want.real_part || out_data.imag_part !== want.imag_part
            || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    row_t dir [$];
    out_t beyond;
    beyond = '0;
    beyond.status = 1'b1;
    build_trig();
    for (int i = 0; i < DEPTH; i++) samples[i] = '0;
    length_reg = LENGTH_RESET;
    hop_reg = HOP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir.push_back('{write_req(0, -32768), 1'b0, '0});
    dir.push_back('{write_req(65535, -32768), 1'b0, '0});
    dir.push_back('{bin_req(0, 0), 1'b0, '0});
    dir.push_back('{write_req(0, 32767), 1'b0, '0});
    dir.push_back('{bin_req(0, 0), 1'b0, '0});
    dir.push_back('{bin_req(0, 2048), 1'b0, '0});
    dir.push_back('{bin_req(0, 4095), 1'b0, '0});
    dir.push_back('{bin_req(0, 1), 1'b0, '0});
    dir.push_back('{bin_req(1, 0), 1'b1, beyond});
    dir.push_back('{bin_req(131071, 4095), 1'b1, beyond});
    dir.push_back('{bin_req(65536, 2048), 1'b1, beyond});
    foreach (dir[k]) send(dir[k].item, dir[k].fixed, dir[k].want);
    drain();

    // zero length and zero hop
    write_reg(REG_SIGNAL_LENGTH, 0);
    write_reg(REG_HOP_SIZE, 0);
    random_traffic(15);
    drain();

    write_reg(REG_SIGNAL_LENGTH, 37);
    write_reg(REG_HOP_SIZE, 3);
    fill_signal();
    gaps_on = 1'b0;
    random_traffic(20);
    gaps_on = 1'b1;
    drain();

    write_reg(REG_SIGNAL_LENGTH, 60);
    write_reg(REG_HOP_SIZE, 8191);
    fill_signal();
    random_traffic(12);
    drain();

    // full depth, frames past the last only
    write_reg(REG_SIGNAL_LENGTH, 65536);
    write_reg(REG_HOP_SIZE, 4096);
    random_traffic(10, 1'b1);
    drain();

    // length above depth
    write_reg(REG_SIGNAL_LENGTH, 131071);
    write_reg(REG_HOP_SIZE, 1);
    random_traffic(10, 1'b1);
    drain();

    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sbe_pkg.sv
rtl/sbe_sig_mem.sv
rtl/sbe_cos_rom.sv
rtl/sbe_mac.sv
rtl/stft_bin_engine.sv
verif/stft_bin_engine_tb.sv
